FILE: hdl/tcsr_pkg.sv
`timescale 1ns / 1ps
// Package for the two-channel servo ramp: widths, codes, sequencer states.
// No dependencies; used by two_channel_servo_ramp and tcsr_chk.
package tcsr_pkg;

  localparam int POS_BITS_DEF     = 12;
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int ID_BITS          = 8;
  localparam int DUR_BITS         = 16;
  localparam int TIME_BITS        = 32;
  localparam int PERIOD_BITS      = 26;
  localparam int TIME_SCALE       = 1000;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_EMIT
  } seq_state_t;

endpackage

FILE: hdl/tcsr_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; instantiated by two_channel_servo_ramp.
module tcsr_div #(
  parameter int W = 26
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem_r, quo_r[W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? W'(trial - {1'b0, dvs_r}) : trial[W-1:0];
      quo_r <= {quo_r[W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/two_channel_servo_ramp.sv
`timescale 1ns / 1ps
// Top level of the two-channel servo ramp generator.
// Depends on tcsr_pkg and tcsr_div.
//
// A start transaction loads a move and computes each channel's step period
// (duration*1000/distance); a tick transaction turns the elapsed time into a
// position per channel (elapsed*1000/period, clamped to the goal). Both use
// one shared bit-serial divider of PERIOD_BITS (26) bits, one channel after
// the other; channels that need no division skip the divider. in_stall is
// high for the whole sequence. A tick while no move is active is accepted and
// yields nothing. The result sits in an output register; a stalled result
// holds up only the next result.
module two_channel_servo_ramp
  import tcsr_pkg::*;
#(
  parameter int POS_BITS     = POS_BITS_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic                 in_two_channels,
  input  logic [DUR_BITS-1:0]  in_duration_ms,
  input  logic [ID_BITS-1:0]   in_servo_a,
  input  logic [POS_BITS-1:0]  in_start_a,
  input  logic [POS_BITS-1:0]  in_goal_a,
  input  logic [ID_BITS-1:0]   in_servo_b,
  input  logic [POS_BITS-1:0]  in_start_b,
  input  logic [POS_BITS-1:0]  in_goal_b,
  input  logic [TIME_BITS-1:0] in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ID_BITS-1:0]   out_servo_a,
  output logic [POS_BITS-1:0]  out_pos_a,
  output logic [ID_BITS-1:0]   out_servo_b,
  output logic [POS_BITS-1:0]  out_pos_b,
  output logic                 out_b_valid,
  output logic                 out_done_res
);

  seq_state_t state_r, state_nxt;
  logic       ch_r, ch_nxt;
  op_t        op_r;
  logic       active_r, first_r;
  logic [TIME_BITS-1:0] begin_r;
  logic [DUR_BITS-1:0]  dur_r;
  logic       dual_r;
  logic       done_r;
  logic [DUR_BITS-1:0]  elap_r;

  logic [ID_BITS-1:0]     id_r  [2];
  logic [POS_BITS-1:0]    org_r [2];
  logic [POS_BITS-1:0]    tgt_r [2];
  logic [PERIOD_BITS-1:0] per_r [2];
  logic [POS_BITS-1:0]    pos_r [2];

  logic                out_valid_r;
  logic [ID_BITS-1:0]  out_servo_a_r, out_servo_b_r;
  logic [POS_BITS-1:0] out_pos_a_r, out_pos_b_r;
  logic                out_b_valid_r, out_done_r;

  logic in_acc, emit, div_go, div_done, last_ch, skip, step_done;
  logic [POS_BITS-1:0]    cur_org, cur_tgt, cur_dist, steps, new_pos;
  logic [PERIOD_BITS-1:0] quotient, div_dvd, div_dvs;
  logic [DUR_BITS-1:0]    mul_in;
  logic [TIME_BITS-1:0]   elapsed;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign cur_org  = org_r[ch_r];
  assign cur_tgt  = tgt_r[ch_r];
  assign cur_dist = (cur_org > cur_tgt) ? cur_org - cur_tgt : cur_tgt - cur_org;
  assign skip     = (op_r == OP_START) ? (cur_dist == '0)
                  : (done_r || cur_dist == '0 || per_r[ch_r] == '0);
  assign last_ch  = ch_r || !dual_r;

  assign mul_in  = (op_r == OP_START) ? dur_r : elap_r;
  assign div_dvd = PERIOD_BITS'(mul_in * TIME_SCALE);
  assign div_dvs = (op_r == OP_START) ? PERIOD_BITS'(cur_dist) : per_r[ch_r];

  assign steps   = (quotient > PERIOD_BITS'(cur_dist)) ? cur_dist
                                                       : quotient[POS_BITS-1:0];
  assign new_pos = (cur_org <= cur_tgt) ? cur_org + steps : cur_org - steps;

  assign elapsed = first_r ? '0 : in_now_ms - begin_r;

  tcsr_div #(.W(PERIOD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    div_go    = 1'b0;
    emit      = 1'b0;
    step_done = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ch_nxt = 1'b0;
        if (in_acc && (in_opcode == OP_START || active_r)) begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (skip) begin
          step_done = 1'b1;
        end else begin
          div_go    = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        step_done = div_done;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (step_done) begin
      if (!last_ch) begin
        ch_nxt    = 1'b1;
        state_nxt = ST_LAUNCH;
      end else begin
        state_nxt = (op_r == OP_START) ? ST_IDLE : ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      first_r  <= 1'b1;
    end else if (in_acc && in_opcode == OP_START) begin
      active_r <= 1'b1;
      first_r  <= 1'b1;
    end else if (in_acc && active_r) begin
      first_r <= 1'b0;
    end else if (emit && done_r) begin
      active_r <= 1'b0;
      first_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= op_t'(in_opcode);
      if (in_opcode == OP_START) begin
        dur_r    <= in_duration_ms;
        dual_r   <= (NUM_CHANNELS >= 2) && in_two_channels;
        id_r[0]  <= in_servo_a;
        org_r[0] <= in_start_a;
        tgt_r[0] <= in_goal_a;
        if ((NUM_CHANNELS >= 2) && in_two_channels) begin
          id_r[1]  <= in_servo_b;
          org_r[1] <= in_start_b;
          tgt_r[1] <= in_goal_b;
        end else begin
          id_r[1]  <= '0;
          org_r[1] <= '0;
          tgt_r[1] <= '0;
        end
      end else if (active_r) begin
        if (first_r) begin
          begin_r <= in_now_ms;
        end
        elap_r <= elapsed[DUR_BITS-1:0];
        done_r <= elapsed >= TIME_BITS'(dur_r);
      end
    end
    if (state_r == ST_LAUNCH && skip) begin
      if (op_r == OP_START) begin
        per_r[ch_r] <= '0;
      end else begin
        pos_r[ch_r] <= cur_tgt;
      end
    end
    if (state_r == ST_WAIT && div_done) begin
      if (op_r == OP_START) begin
        per_r[ch_r] <= quotient;
      end else begin
        pos_r[ch_r] <= new_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_servo_a_r <= id_r[0];
      out_pos_a_r   <= pos_r[0];
      out_servo_b_r <= dual_r ? id_r[1] : '0;
      out_pos_b_r   <= dual_r ? pos_r[1] : '0;
      out_b_valid_r <= dual_r;
      out_done_r    <= done_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_servo_a  = out_servo_a_r;
  assign out_pos_a    = out_pos_a_r;
  assign out_servo_b  = out_servo_b_r;
  assign out_pos_b    = out_pos_b_r;
  assign out_b_valid  = out_b_valid_r;
  assign out_done_res = out_done_r;

endmodule

FILE: hdl/tcsr_chk.sv
`timescale 1ns / 1ps
// Port-level checker for two_channel_servo_ramp, bound to the top level.
// Depends on tcsr_pkg.
module tcsr_chk
  import tcsr_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                in_opcode,
  input logic                out_valid,
  input logic                out_stall,
  input logic [ID_BITS-1:0]  out_servo_b,
  input logic [POS_BITS-1:0] out_pos_a,
  input logic [POS_BITS-1:0] out_pos_b,
  input logic                out_b_valid,
  input logic                out_done_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_a) && $stable(out_done_res))
    else $error("stalled result changed");

  a_b_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_b_valid |-> out_servo_b == '0 && out_pos_b == '0)
    else $error("second channel fields set on single-channel move");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == OP_START |=> in_stall)
    else $error("start transaction not followed by busy");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

bind two_channel_servo_ramp tcsr_chk #(.POS_BITS(POS_BITS)) u_tcsr_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_opcode    (in_opcode),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_servo_b  (out_servo_b),
  .out_pos_a    (out_pos_a),
  .out_pos_b    (out_pos_b),
  .out_b_valid  (out_b_valid),
  .out_done_res (out_done_res)
);
